>>> hw/rtl/cfkc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfkc_pkg: shared types and constants
// Widths, CORDIC arctangent table and sequencer states for the link chain.
// ---------------------------------------------------------------------------
package cfkc_pkg;

   localparam int MAX_LINKS    = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int JIDX_W       = $clog2(MAX_LINKS);
   localparam int JCNT_W       = $clog2(MAX_LINKS + 1);
   localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

   localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] POS_MIN = -24'sh800000;
   localparam logic signed [15:0] QUARTER_TURN = 16'sd16384;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sh26DD3B6A;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ANGLE     = 2'd1,
      STATUS_COLLISION = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CORDIC_P, ST_CORDIC_Y, ST_MUL_X, ST_MUL_Y,
      ST_MUL_RX, ST_MUL_RY, ST_MUL_RZ, ST_ACCUM, ST_CHECK, ST_STORE, ST_OUT
   } state_type;

   // arctangent table, pi = 2^23
   function automatic logic signed [23:0] atan_lookup(input logic [4:0] i);
      case (i)
         5'd0:  atan_lookup = 24'sd2097152;
         5'd1:  atan_lookup = 24'sd1238021;
         5'd2:  atan_lookup = 24'sd654136;
         5'd3:  atan_lookup = 24'sd332050;
         5'd4:  atan_lookup = 24'sd166669;
         5'd5:  atan_lookup = 24'sd83416;
         5'd6:  atan_lookup = 24'sd41718;
         5'd7:  atan_lookup = 24'sd20860;
         5'd8:  atan_lookup = 24'sd10430;
         5'd9:  atan_lookup = 24'sd5215;
         5'd10: atan_lookup = 24'sd2608;
         5'd11: atan_lookup = 24'sd1304;
         5'd12: atan_lookup = 24'sd652;
         5'd13: atan_lookup = 24'sd326;
         5'd14: atan_lookup = 24'sd163;
         5'd15: atan_lookup = 24'sd81;
         5'd16: atan_lookup = 24'sd41;
         5'd17: atan_lookup = 24'sd20;
         5'd18: atan_lookup = 24'sd10;
         5'd19: atan_lookup = 24'sd5;
         5'd20: atan_lookup = 24'sd3;
         5'd21: atan_lookup = 24'sd1;
         5'd22: atan_lookup = 24'sd1;
         default: atan_lookup = 24'sd0;
      endcase
   endfunction

endpackage

>>> hw/rtl/cfkc_cordic.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfkc_cordic: iterative sine and cosine
// One shift-add CORDIC rotation per cycle; quadrant folding by pi.
// ---------------------------------------------------------------------------
module cfkc_cordic
   import cfkc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [15:0]  angle,
   output logic                done,
   output logic signed [33:0]  sin_out,
   output logic signed [33:0]  cos_out
);

   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [24:0] z_ff, z_in;
   logic               neg_ff, neg_in;
   logic               busy_ff, busy_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic signed [16:0] a_fold;
   logic signed [33:0] xs, ys;
   logic signed [24:0] atan_v;

   // fold angle into [-pi/2, pi/2]
   always_comb begin
      a_fold = 17'(angle);
      neg_in = neg_ff;
      if (start) begin
         neg_in = 1'b0;
         if (angle > QUARTER_TURN) begin
            a_fold = 17'(angle) - 17'sd32768;
            neg_in = 1'b1;
         end else if (angle < -QUARTER_TURN) begin
            a_fold = 17'(angle) + 17'sd32768;
            neg_in = 1'b1;
         end
      end
   end

   // one rotation step
   always_comb begin
      xs     = x_ff >>> step_ff;
      ys     = y_ff >>> step_ff;
      atan_v = 25'(atan_lookup(5'(step_ff)));
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      busy_in = busy_ff; step_in = step_ff;
      if (start) begin
         x_in = CORDIC_GAIN; y_in = '0;
         z_in = 25'({a_fold, 8'd0});
         busy_in = 1'b1; step_in = '0;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + atan_v;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; neg_ff <= neg_in;
   end

   assign done    = ~busy_ff;
   assign cos_out = neg_ff ? -x_ff : x_ff;
   assign sin_out = neg_ff ? -y_ff : y_ff;

endmodule

>>> hw/rtl/chain_forward_kinematics_collision_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chain_forward_kinematics_collision_top: link chain tip position
// Accumulates spherical link offsets and checks joints for collisions.
// ---------------------------------------------------------------------------
// a link runs two CORDIC rotations (pitch, then yaw), six multiply and add
// steps and a walk over the stored joints, then stores its joint if no
// collision is found; an angle fault or sticky error goes straight from the
// pitch CORDIC state to the output state. one link is taken at a time; after
// a last link the next is accepted after the result is taken. reset clears
// position, joint count and error; the joint memory is not cleared, only
// entries below the count are read.
module chain_forward_kinematics_collision_top
   import cfkc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // link_number, link_length, pitch_angle, yaw_angle
   input  logic        req_tlast,   // last_link
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // pos_x, pos_y, pos_z
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_data
);

   state_type state_ff, state_in;
   logic [23:0]        thr_ff;
   logic [7:0]         id_ff;
   logic [15:0]        len_ff;
   logic signed [15:0] pitch_ff, yaw_ff;
   logic               last_ff;
   logic signed [23:0] acc_x_ff, acc_y_ff, acc_z_ff;
   logic signed [33:0] sp_ff, cp_ff, t_ff;
   logic signed [33:0] dx_ff, dy_ff;
   logic [JCNT_W-1:0]  jcnt_ff, k_ff;
   logic [1:0]         err_ff;
   logic [71:0]        jmem [MAX_LINKS];
   logic [71:0]        jrd_ff;
   logic               rd_ok_ff, rd_ok_in;
   logic [71:0]        out_ff;
   logic [1:0]         stat_ff;

   logic               cs_start, cs_done;
   logic signed [15:0] cs_angle;
   logic signed [33:0] cs_sin, cs_cos;

   cfkc_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cs_start), .angle(cs_angle),
      .done(cs_done), .sin_out(cs_sin), .cos_out(cs_cos)
   );

   // shared multiplier, rounded by 2^30
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod;
   logic signed [37:0] rnd;
   always_comb begin
      mul_a = t_ff; mul_b = sp_ff;
      case (state_ff)
         ST_MUL_X:  begin mul_a = cs_cos; mul_b = sp_ff; end
         ST_MUL_Y:  begin mul_a = cs_sin; mul_b = sp_ff; end
         ST_MUL_RX: begin mul_a = 34'(len_ff); mul_b = dx_ff; end
         ST_MUL_RY: begin mul_a = 34'(len_ff); mul_b = dy_ff; end
         ST_MUL_RZ: begin mul_a = 34'(len_ff); mul_b = cp_ff; end
         default:   begin mul_a = t_ff; mul_b = sp_ff; end
      endcase
      prod = mul_a * mul_b;
      rnd  = 38'((prod + 68'sd536870912) >>> 30);
   end

   // saturating add
   function automatic logic signed [23:0] sat_add(input logic signed [23:0] a,
                                                  input logic signed [37:0] d);
      logic signed [38:0] t;
      t = 39'(a) + 39'(d);
      if (t > 39'(POS_MAX))      sat_add = POS_MAX;
      else if (t < 39'(POS_MIN)) sat_add = POS_MIN;
      else                       sat_add = t[23:0];
   endfunction

   // squared distance to the fetched joint
   logic signed [24:0] ex, ey, ez;
   logic [51:0]        d2;
   always_comb begin
      ex = 25'(acc_x_ff) - 25'($signed(jrd_ff[23:0]));
      ey = 25'(acc_y_ff) - 25'($signed(jrd_ff[47:24]));
      ez = 25'(acc_z_ff) - 25'($signed(jrd_ff[71:48]));
      d2 = 52'(ex * ex) + 52'(ey * ey) + 52'(ez * ez);
   end

   logic angle_bad;
   assign angle_bad = (id_ff == 8'd1) &&
                      ((pitch_ff > QUARTER_TURN) || (yaw_ff > QUARTER_TURN));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_CORDIC_P;
         ST_CORDIC_P: begin
            if (err_ff != STATUS_OK || angle_bad) state_in = ST_OUT;
            else if (cs_done && rd_ok_ff) state_in = ST_CORDIC_Y;
         end
         ST_CORDIC_Y: if (cs_done && rd_ok_ff) state_in = ST_MUL_X;
         ST_MUL_X:    state_in = ST_MUL_Y;
         ST_MUL_Y:    state_in = ST_MUL_RX;
         ST_MUL_RX:   state_in = ST_MUL_RY;
         ST_MUL_RY:   state_in = ST_MUL_RZ;
         ST_MUL_RZ:   state_in = ST_ACCUM;
         ST_ACCUM:    state_in = ST_CHECK;
         ST_CHECK: begin
            if (k_ff >= jcnt_ff) state_in = ST_STORE;
            else if (rd_ok_ff && d2 < 52'(thr_ff)) state_in = ST_OUT;
         end
         ST_STORE:    state_in = ST_OUT;
         ST_OUT:      if (!last_ff || rsp_tready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs and handshakes
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      csr_ready  = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_OUT) && last_ff;
      rsp_tdata  = out_ff;
      rsp_tuser  = stat_ff;
      cs_start   = (state_ff == ST_CORDIC_P || state_ff == ST_CORDIC_Y) && !rd_ok_ff;
      cs_angle   = (state_ff == ST_CORDIC_P) ? pitch_ff : yaw_ff;
   end

   // read-valid flag: cordic handoff and joint fetch
   always_comb begin
      case (state_ff)
         ST_CORDIC_P, ST_CORDIC_Y: rd_ok_in = !(cs_done && rd_ok_ff);
         ST_CHECK:                 rd_ok_in = (k_ff < jcnt_ff) && !rd_ok_ff;
         default:                  rd_ok_in = 1'b0;
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         thr_ff   <= 24'd655;
         acc_x_ff <= '0; acc_y_ff <= '0; acc_z_ff <= '0;
         jcnt_ff  <= '0;
         err_ff   <= STATUS_OK;
         rd_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) thr_ff <= csr_data;
         rd_ok_ff <= rd_ok_in;
         case (state_ff)
            ST_IDLE: if (req_tvalid) begin
               id_ff <= req_tdata[7:0]; len_ff <= req_tdata[23:8];
               pitch_ff <= $signed(req_tdata[39:24]);
               yaw_ff <= $signed(req_tdata[55:40]);
               last_ff <= req_tlast;
            end
            ST_CORDIC_P: begin
               if (err_ff == STATUS_OK && angle_bad) err_ff <= STATUS_ANGLE;
               if (cs_done && rd_ok_ff) begin sp_ff <= cs_sin; cp_ff <= cs_cos; end
            end
            ST_MUL_X:  dx_ff <= 34'(rnd);
            ST_MUL_Y:  dy_ff <= 34'(rnd);
            ST_MUL_RX: t_ff <= 34'(rnd);
            ST_MUL_RY: begin acc_x_ff <= sat_add(acc_x_ff, 38'(t_ff)); t_ff <= 34'(rnd); end
            ST_MUL_RZ: begin acc_y_ff <= sat_add(acc_y_ff, 38'(t_ff)); t_ff <= 34'(rnd); end
            ST_ACCUM:  begin acc_z_ff <= sat_add(acc_z_ff, 38'(t_ff)); k_ff <= '0; end
            ST_CHECK: begin
               if (k_ff < jcnt_ff && rd_ok_ff) begin
                  if (d2 < 52'(thr_ff)) err_ff <= STATUS_COLLISION;
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_STORE: if (jcnt_ff < JCNT_W'(MAX_LINKS)) jcnt_ff <= jcnt_ff + 1'b1;
            ST_OUT: if (last_ff && rsp_tready) begin
               acc_x_ff <= '0; acc_y_ff <= '0; acc_z_ff <= '0;
               jcnt_ff <= '0; err_ff <= STATUS_OK;
            end
            default: ;
         endcase
         // result register loads while heading into the output state
         if (state_in == ST_OUT && state_ff != ST_OUT) begin
            if (state_ff == ST_STORE && err_ff == STATUS_OK) begin
               out_ff  <= {acc_z_ff, acc_y_ff, acc_x_ff};
               stat_ff <= STATUS_OK;
            end else begin
               out_ff  <= '0;
               stat_ff <= (state_ff == ST_CHECK) ? STATUS_COLLISION :
                          (err_ff != STATUS_OK) ? err_ff : STATUS_ANGLE;
            end
         end
      end
   end

   // joint memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == ST_STORE && jcnt_ff < JCNT_W'(MAX_LINKS))
         jmem[jcnt_ff[JIDX_W-1:0]] <= {acc_z_ff, acc_y_ff, acc_x_ff};
      jrd_ff <= jmem[k_ff[JIDX_W-1:0]];
   end

`ifndef NO_ASSERTIONS
   a_rsp_only_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> state_ff == ST_OUT) else $error("response outside output state");
   a_jcnt_bound: assert property (@(posedge clock) disable iff (reset)
      jcnt_ff <= JCNT_W'(MAX_LINKS)) else $error("joint count overflow");
   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_OK) |-> rsp_tdata == '0)
      else $error("error result not zero");
`endif

endmodule

>>> dv/chain_forward_kinematics_collision_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chain_forward_kinematics_collision_checker: tip position scoreboard
// Watches the link, result and threshold channels, rebuilds the tip position
// with a bit-exact CORDIC and joint walk, and compares every result transfer.
// ---------------------------------------------------------------------------
module chain_forward_kinematics_collision_checker
   import cfkc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,   // link_number, link_length, pitch_angle, yaw_angle
   input  logic        req_tlast,   // last_link
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,   // pos_x, pos_y, pos_z
   input  logic [1:0]  rsp_tuser,   // status
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [23:0] csr_data,
   output int          fail_count,
   output int          tips_pending,
   output int          tips_seen,
   output int          collisions_seen,
   output int          angle_faults_seen
);

   typedef struct {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      status_type         status;
   } tip_type;

   localparam longint ARCTAN [0:15] = '{
      2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
      10430, 5215, 2608, 1304, 652, 326, 163, 81
   };

   tip_type    tip_queue[$];
   logic [23:0] threshold;
   longint     tip_x, tip_y, tip_z;
   longint     joint_x[MAX_LINKS], joint_y[MAX_LINKS], joint_z[MAX_LINKS];
   int         joint_total;
   status_type chain_status;

   assign tips_pending = tip_queue.size();

   // rotation-mode cordic on a 16 bit angle code
   function automatic void rotate_angle(input int code, output longint sin_v,
                                        output longint cos_v);
      longint x, y, z, xs, ys;
      bit     flip;
      x = 64'h26DD3B6A;
      y = 0;
      flip = 0;
      if (code > 16384) begin
         code = code - 32768;
         flip = 1;
      end else if (code < -16384) begin
         code = code + 32768;
         flip = 1;
      end
      z = longint'(code) * 256;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - ARCTAN[i];
         end else begin
            x = x + ys; y = y - xs; z = z + ARCTAN[i];
         end
      end
      cos_v = flip ? -x : x;
      sin_v = flip ? -y : y;
   endfunction

   function automatic longint round30(input longint p);
      return (p + (longint'(1) << 29)) >>> 30;
   endfunction

   function automatic longint clamp_pos(input longint a, input longint d);
      longint t;
      t = a + d;
      if (t > 8388607) return 8388607;
      if (t < -8388608) return -8388608;
      return t;
   endfunction

   // one link: angle check, offset, joint walk, store
   task automatic advance_tip(input int id, input longint len, input int pitch,
                              input int yaw);
      longint sp, cp, sy, cy, dx, dy, dz;
      if (id == 1 && (pitch > 16384 || yaw > 16384)) begin
         chain_status = STATUS_ANGLE;
         return;
      end
      rotate_angle(pitch, sp, cp);
      rotate_angle(yaw, sy, cy);
      tip_x = clamp_pos(tip_x, round30(len * round30(cy * sp)));
      tip_y = clamp_pos(tip_y, round30(len * round30(sy * sp)));
      tip_z = clamp_pos(tip_z, round30(len * cp));
      for (int k = 0; k < joint_total; k++) begin
         dx = tip_x - joint_x[k];
         dy = tip_y - joint_y[k];
         dz = tip_z - joint_z[k];
         if (dx * dx + dy * dy + dz * dz < longint'(threshold)) begin
            chain_status = STATUS_COLLISION;
            return;
         end
      end
      if (joint_total < MAX_LINKS) begin
         joint_x[joint_total] = tip_x;
         joint_y[joint_total] = tip_y;
         joint_z[joint_total] = tip_z;
         joint_total++;
      end
   endtask

   task automatic report_mismatch(input string field, input longint got,
                                  input longint want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      tips_seen = 0;
      collisions_seen = 0;
      angle_faults_seen = 0;
   end

   always @(posedge clock) begin
      tip_type t;
      if (reset) begin
         threshold = 24'd655;
         tip_x = 0; tip_y = 0; tip_z = 0;
         joint_total = 0;
         chain_status = STATUS_OK;
         tip_queue.delete();
      end else begin
         // result transfer against oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (tip_queue.size() == 0) begin
               $display("%0t result transfer with nothing expected", $time);
               fail_count++;
            end else begin
               t = tip_queue.pop_front();
               if ($signed(rsp_tdata[23:0]) != t.x)
                  report_mismatch("pos_x", $signed(rsp_tdata[23:0]), t.x);
               if ($signed(rsp_tdata[47:24]) != t.y)
                  report_mismatch("pos_y", $signed(rsp_tdata[47:24]), t.y);
               if ($signed(rsp_tdata[71:48]) != t.z)
                  report_mismatch("pos_z", $signed(rsp_tdata[71:48]), t.z);
               if (rsp_tuser != t.status)
                  report_mismatch("status", rsp_tuser, t.status);
            end
            tips_seen++;
         end
         if (csr_valid && csr_ready)
            threshold = csr_data;
         // link transfer
         if (req_tvalid && req_tready) begin
            if (chain_status == STATUS_OK)
               advance_tip(req_tdata[7:0], req_tdata[23:8],
                           $signed(req_tdata[39:24]), $signed(req_tdata[55:40]));
            if (req_tlast) begin
               t.status = chain_status;
               t.x = (chain_status == STATUS_OK) ? tip_x[23:0] : '0;
               t.y = (chain_status == STATUS_OK) ? tip_y[23:0] : '0;
               t.z = (chain_status == STATUS_OK) ? tip_z[23:0] : '0;
               tip_queue = {tip_queue, t};
               if (chain_status == STATUS_COLLISION) collisions_seen++;
               if (chain_status == STATUS_ANGLE) angle_faults_seen++;
               tip_x = 0; tip_y = 0; tip_z = 0;
               joint_total = 0;
               chain_status = STATUS_OK;
            end
         end
      end
   end

   final begin
      if (tip_queue.size() != 0)
         $display("%0d results never arrived", tip_queue.size());
   end

endmodule

>>> dv/chain_forward_kinematics_collision_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chain_forward_kinematics_collision_top_tb: link chain testbench
// Sends directed and random arm chains in bursts under several collision
// thresholds while the result side stalls; a checker scores each tip.
// ---------------------------------------------------------------------------
module chain_forward_kinematics_collision_top_tb;
   import cfkc_pkg::*;

   localparam int ITEM_TARGET = 1350;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 100;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;   // link_number, link_length, pitch_angle, yaw_angle
   logic        req_tlast = 0;    // last_link
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;        // pos_x, pos_y, pos_z
   logic [1:0]  rsp_tuser;        // status
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [23:0] csr_data = '0;

   int fail_count, tips_pending, tips_seen, collisions_seen, angle_faults_seen;
   int links_sent = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int cycle_count = 0;

   chain_forward_kinematics_collision_top dut (.*);

   chain_forward_kinematics_collision_checker checker_i (.*);

   // clock
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // result side stall pattern: open, coin flip, then sparse
   always @(negedge clock) begin
      cycle_count++;
      case ((cycle_count / 700) % 3)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (cycle_count % 9 == 0);
      endcase
   end

   // one link transfer, bursts with random gaps
   task automatic send_link(input logic [7:0] id, input logic [15:0] len,
                            input logic [15:0] pitch, input logic [15:0] yaw,
                            input logic last);
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 20)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
      end
      req_tdata = {yaw, pitch, len, id};
      req_tlast = last;
      req_tvalid = 1;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      links_sent++;
   endtask

   // hold off until all tips are back and the block has gone quiet
   task automatic drain_chains();
      @(negedge clock);
      req_tvalid = 0;
      burst_left = 0;
      while (tips_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [23:0] value);
      @(negedge clock);
      csr_data = value;
      csr_valid = 1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic logic [15:0] pick_angle(input bit first);
      if (first && $urandom_range(0, 99) < 85)
         return 16'($signed($urandom_range(0, 32768)) - 16384);
      return 16'($urandom);
   endfunction

   // random chain: plain, folding back on itself, or straight and long
   task automatic random_chain();
      int          kind, count;
      logic [7:0]  id;
      logic [15:0] len, pitch, yaw;
      bit          seq;
      kind = $urandom_range(0, 99);
      seq = ($urandom_range(0, 9) != 0);
      if (kind < 4) begin
         count = $urandom_range(20, 140);
         len = 16'hFFFF - 16'($urandom_range(0, 3));
         pitch = ($urandom_range(0, 1) != 0) ? 16'sd16384 : 16'h8000;
         yaw = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'h8000;
         for (int i = 1; i <= count; i++)
            send_link(seq ? 8'(i) : 8'($urandom), len, pitch, yaw, i == count);
      end else begin
         count = $urandom_range(1, 20);
         len = 0; pitch = 0; yaw = 0;
         for (int i = 1; i <= count; i++) begin
            id = seq ? 8'(i) : 8'($urandom);
            if (kind < 40 && i > 1 && $urandom_range(0, 2) == 0) begin
               // retrace the previous link toward the earlier joint
               pitch = pitch + 16'h8000;
            end else begin
               len = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 255))
                                                 : 16'($urandom);
               pitch = pick_angle(id == 1);
               yaw = pick_angle(id == 1);
            end
            send_link(id, len, pitch, yaw, i == count);
         end
      end
   endtask

   initial begin
      logic [23:0] thresholds [6];
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed chains under the reset threshold
      send_link(8'd1, 16'hFFFF, 16'sd16384, 16'sd16384, 1);
      send_link(8'd1, 16'd100, 16'sd16385, 16'sd0, 0);
      send_link(8'd2, 16'hFFFF, 16'sd0, 16'sd0, 0);
      send_link(8'd3, 16'd5, 16'sd0, 16'sd0, 1);
      send_link(8'd1, 16'd300, -16'sd16384, 16'sd16385, 1);
      send_link(8'd2, 16'hFFFF, 16'h8000, 16'h7FFF, 0);
      send_link(8'd3, 16'd0, 16'h7FFF, 16'h8000, 0);
      send_link(8'd0, 16'd1, -16'sd16385, 16'sd16385, 0);
      send_link(8'd4, 16'd9, 16'sd1, 16'sd2, 1);
      send_link(8'd1, 16'd0, -16'sd16384, 16'h8000, 0);
      send_link(8'd2, 16'd0, 16'sd0, 16'sd0, 1);
      send_link(8'd255, 16'd1000, 16'sd8192, -16'sd8192, 0);
      send_link(8'd1, 16'd1, 16'h7FFF, 16'h7FFF, 0);
      send_link(8'd128, 16'hFFFF, 16'sd16384, 16'sd0, 0);
      send_link(8'd5, 16'hFFFF, 16'h8000, 16'sd0, 1);
      send_link(8'd1, 16'd256, -16'sd32768, -16'sd32768, 1);
      // wait out every result before the random phases
      drain_chains();

      thresholds = '{24'd0, 24'hFFFFFF, 24'd655, 24'($urandom),
                     24'($urandom_range(0, 4096)), 24'd1};
      for (int p = 0; p < 6; p++) begin
         write_threshold(thresholds[p]);
         while (links_sent < (p + 1) * ITEM_TARGET / 6) random_chain();
         drain_chains();
      end

      $display("sent %0d links, %0d tips checked (%0d collisions, %0d angle faults)",
               links_sent, tips_seen, collisions_seen, angle_faults_seen);
      $display("thresholds covered zero, full scale, reset value and random settings");
      if (fail_count == 0 && tips_pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
